### design/madc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madc_pkg
// Shared types, codes and saturation helpers for the multislope ADC
// autozero reading block.
// ----------------------------------------------------------------------------
package madc_pkg;

  // Fixed widths of the arithmetic.
  localparam int CNT_W = 36;   // one packet count, signed
  localparam int SUM_W = 40;   // phase sums, signed
  localparam int DIF_W = 41;   // signal minus zero, signed
  localparam int RD_W  = 48;   // reading, signed
  localparam int ACC_W = 80;   // multiplier accumulator
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 48;

  // Defaults for the top-level parameters.
  localparam int MAX_AVERAGE_DEF       = 10;
  localparam int READING_FRAC_BITS_DEF = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ADC_STEP    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_SCALE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_COUNT   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_CODE  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_OFFSET  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_GAIN    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_OFFSET  = 4'd7;

  // Range codes.
  localparam logic [3:0] RNG_1V    = 4'd0;
  localparam logic [3:0] RNG_10V   = 4'd1;
  localparam logic [3:0] RNG_100V  = 4'd2;
  localparam logic [3:0] RNG_1K    = 4'd3;
  localparam logic [3:0] RNG_10K   = 4'd4;
  localparam logic [3:0] RNG_100K  = 4'd5;
  localparam logic [3:0] RNG_1M    = 4'd6;
  localparam logic [3:0] RNG_10M   = 4'd7;
  localparam logic [3:0] RNG_DIODE = 4'd8;
  localparam logic [3:0] RNG_LAST  = 4'd11;

  // Autozero phases.
  localparam logic [2:0] PH_DROP_SIG  = 3'd0;
  localparam logic [2:0] PH_SIGNAL    = 3'd1;
  localparam logic [2:0] PH_DROP_ZERO = 3'd2;
  localparam logic [2:0] PH_ZERO      = 3'd3;

  // Overload limits, in hundredths of the reading unit.
  localparam logic [16:0] LIM_HIGH = 17'd102000;
  localparam logic [16:0] LIM_MID  = 17'd10200;
  localparam logic [16:0] LIM_LOW  = 17'd1020;

  localparam logic [3:0] DIV_TEN = 4'd10;

  // Largest 1 V magnitude: a saturated mean divided by ten.
  localparam logic [63:0] MAG_1V_MAX = 64'h0000_0CCC_CCCC_CCCC;

  localparam logic signed [RD_W-1:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [RD_W-1:0] MIN48 = 48'sh8000_0000_0000;

  // Datapath operations.
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_PHASE,
    DP_DIFF,
    DP_MUL_LO,
    DP_MUL_HI,
    DP_MUL_ACC,
    DP_DIV_BASE,
    DP_DIV_STEP,
    DP_QUO_SAT,
    DP_PRE,
    DP_OFFSET,
    DP_GAIN_LOAD,
    DP_GAIN_SAT,
    DP_REL,
    DP_FINISH
  } dp_op_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic reading_due;
    logic div_last;
    logic out_busy;
  } madc_sts_t;

  // Clamp a signed value to the 48-bit signed range.
  function automatic logic signed [RD_W-1:0] sat48(input logic signed [63:0] x);
    logic signed [RD_W-1:0] r;
    if (x > 64'(MAX48)) begin
      r = MAX48;
    end else if (x < 64'(MIN48)) begin
      r = MIN48;
    end else begin
      r = x[RD_W-1:0];
    end
    return r;
  endfunction

  // Build a saturated signed value from a sign and a magnitude.
  function automatic logic signed [RD_W-1:0] sgn_sat48(input logic neg,
                                                       input logic [63:0] m);
    logic [63:0] mm;
    logic signed [RD_W-1:0] r;
    mm = (m > 64'h8000_0000_0000) ? 64'h8000_0000_0000 : m;
    if (neg) begin
      r = -$signed(mm[RD_W-1:0]);
    end else if (mm == 64'h8000_0000_0000) begin
      r = MAX48;
    end else begin
      r = $signed(mm[RD_W-1:0]);
    end
    return r;
  endfunction

  // Magnitude of a 48-bit signed value.
  function automatic logic [RD_W-1:0] mag48(input logic signed [RD_W-1:0] v);
    return v[RD_W-1] ? RD_W'(-v) : RD_W'(v);
  endfunction

endpackage

### design/madc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madc_in_if
// Packet channel: one ADC result packet per transaction.
// ----------------------------------------------------------------------------
interface madc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] up_count;
  logic [11:0] total_count;
  logic        rundown_sign;
  logic [15:0] rundown_count;

  modport source (output valid, up_count, total_count, rundown_sign, rundown_count,
                  input ready);
  modport sink (input valid, up_count, total_count, rundown_sign, rundown_count,
                output ready);
endinterface

### design/madc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madc_out_if
// Result channel: one result per packet transaction.
// ----------------------------------------------------------------------------
interface madc_out_if;
  logic               valid;
  logic               ready;
  logic               switch_to_zero;
  logic               switch_to_signal;
  logic               reading_valid;
  logic signed [47:0] reading;
  logic               overload;

  modport source (output valid, switch_to_zero, switch_to_signal, reading_valid,
                  reading, overload, input ready);
  modport sink (input valid, switch_to_zero, switch_to_signal, reading_valid,
                reading, overload, output ready);
endinterface

### design/madc_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface madc_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/madc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madc_ctrl
// Sequencer that steps the datapath through packet intake, autozero phase
// update and the reading computation.
// ----------------------------------------------------------------------------
module madc_ctrl
  import madc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  input  madc_sts_t sts,
  output dp_op_t    op
);

  typedef enum logic [21:0] {
    S_IDLE     = 22'h000001,
    S_PHASE    = 22'h000002,
    S_CHECK    = 22'h000004,
    S_DIFF     = 22'h000008,
    S_BMUL_LO  = 22'h000010,
    S_BMUL_HI  = 22'h000020,
    S_BMUL_ACC = 22'h000040,
    S_BDIV_LD  = 22'h000080,
    S_BDIV     = 22'h000100,
    S_BSAT     = 22'h000200,
    S_PRE      = 22'h002000,
    S_OFFSET   = 22'h004000,
    S_GLOAD    = 22'h008000,
    S_GMUL_LO  = 22'h010000,
    S_GMUL_HI  = 22'h020000,
    S_GMUL_ACC = 22'h040000,
    S_GSAT     = 22'h080000,
    S_REL      = 22'h100000,
    S_DONE     = 22'h200000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath command.
  always_comb begin
    state_nxt = state_r;
    op        = DP_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = DP_LOAD;
          state_nxt = S_PHASE;
        end
      end
      S_PHASE: begin
        op        = DP_PHASE;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = sts.reading_due ? S_DIFF : S_DONE;
      end
      S_DIFF: begin
        op        = DP_DIFF;
        state_nxt = S_BMUL_LO;
      end
      S_BMUL_LO: begin
        op        = DP_MUL_LO;
        state_nxt = S_BMUL_HI;
      end
      S_BMUL_HI: begin
        op        = DP_MUL_HI;
        state_nxt = S_BMUL_ACC;
      end
      S_BMUL_ACC: begin
        op        = DP_MUL_ACC;
        state_nxt = S_BDIV_LD;
      end
      S_BDIV_LD: begin
        op        = DP_DIV_BASE;
        state_nxt = S_BDIV;
      end
      S_BDIV: begin
        op = DP_DIV_STEP;
        if (sts.div_last) begin
          state_nxt = S_BSAT;
        end
      end
      S_BSAT: begin
        op        = DP_QUO_SAT;
        state_nxt = S_PRE;
      end
      S_PRE: begin
        op        = DP_PRE;
        state_nxt = S_OFFSET;
      end
      S_OFFSET: begin
        op        = DP_OFFSET;
        state_nxt = S_GLOAD;
      end
      S_GLOAD: begin
        op        = DP_GAIN_LOAD;
        state_nxt = S_GMUL_LO;
      end
      S_GMUL_LO: begin
        op        = DP_MUL_LO;
        state_nxt = S_GMUL_HI;
      end
      S_GMUL_HI: begin
        op        = DP_MUL_HI;
        state_nxt = S_GMUL_ACC;
      end
      S_GMUL_ACC: begin
        op        = DP_MUL_ACC;
        state_nxt = S_GSAT;
      end
      S_GSAT: begin
        op        = DP_GAIN_SAT;
        state_nxt = S_REL;
      end
      S_REL: begin
        op        = DP_REL;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy || out_ready) begin
          op        = DP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/madc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madc_dp
// Datapath: configuration registers, packet count, autozero sums, shared
// multiplier, bit-serial divider and the output register.
// ----------------------------------------------------------------------------
module madc_dp
  import madc_pkg::*;
#(
  parameter int MAX_AVERAGE       = MAX_AVERAGE_DEF,
  parameter int READING_FRAC_BITS = READING_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_op_t                   op,
  output madc_sts_t                sts,
  // Packet fields.
  input  logic [15:0]              up_count,
  input  logic [11:0]              total_count,
  input  logic                     rundown_sign,
  input  logic [15:0]              rundown_count,
  // Configuration writes.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DAT_W-1:0]     cfg_data,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_switch_to_zero,
  output logic                     out_switch_to_signal,
  output logic                     out_reading_valid,
  output logic signed [RD_W-1:0]   out_reading,
  output logic                     out_overload
);

  localparam int NW   = $clog2(MAX_AVERAGE + 1);
  localparam int DVW  = $clog2(10 * MAX_AVERAGE + 1);
  localparam int SHR  = 48 - READING_FRAC_BITS;
  localparam int QW   = 25 + READING_FRAC_BITS;
  localparam int DW   = (QW > RD_W) ? QW : RD_W;
  localparam int DCW  = $clog2(DW + 1);

  // Configuration registers.
  logic [15:0]              adc_step_r;
  logic signed [15:0]       zero_off_r;
  logic [31:0]              scale_r;
  logic [3:0]               avg_r;
  logic [3:0]               range_r;
  logic signed [RD_W-1:0]   cal_off_r;
  logic [31:0]              gain_r;
  logic signed [RD_W-1:0]   rel_r;

  // Autozero state.
  logic [2:0]               phase_r;
  logic [NW-1:0]            sc_r;
  logic signed [SUM_W-1:0]  sig_sum_r;
  logic signed [SUM_W-1:0]  zero_sum_r;
  logic signed [CNT_W-1:0]  cnt_r;
  logic                     to_zero_r;
  logic                     to_sig_r;
  logic                     rd_due_r;

  // Arithmetic registers.
  logic [RD_W-1:0]          mop_r;
  logic                     gain_sel_r;
  logic [63:0]              prod_r;
  logic [ACC_W-1:0]         acc_r;
  logic                     neg_r;
  logic signed [RD_W-1:0]   v_r;
  logic [DW-1:0]            div_q_r;
  logic [DVW-1:0]           div_rem_r;
  logic [DVW-1:0]           div_d_r;
  logic [DCW-1:0]           div_cnt_r;

  // Output register.
  logic                     out_valid_r;
  logic                     out_tz_r;
  logic                     out_ts_r;
  logic                     out_rv_r;
  logic signed [RD_W-1:0]   out_rd_r;
  logic                     out_ovl_r;

  // Effective averaging count and range.
  logic [NW-1:0] n_w;
  logic [3:0]    rc_w;
  always_comb begin
    if (avg_r == 4'd0) begin
      n_w = NW'(1);
    end else if (32'(avg_r) > MAX_AVERAGE) begin
      n_w = NW'(MAX_AVERAGE);
    end else begin
      n_w = NW'(avg_r);
    end
    rc_w = (range_r > RNG_LAST) ? RNG_10V : range_r;
  end

  // Signed count of one packet.
  logic [11:0]              half_w;
  logic signed [17:0]       hu_w;
  logic signed [16:0]       step_w;
  logic signed [34:0]       prodc_w;
  logic signed [17:0]       rdn_w;
  logic signed [17:0]       r_w;
  logic signed [CNT_W-1:0]  cnt_w;
  always_comb begin
    half_w  = 12'((13'(total_count) + 13'd1) >> 1);
    hu_w    = $signed({6'd0, half_w}) - $signed({2'd0, up_count});
    step_w  = $signed({1'b0, adc_step_r});
    prodc_w = hu_w * step_w;
    rdn_w   = $signed({2'd0, rundown_count});
    r_w     = rundown_sign ? (rdn_w + {{2{zero_off_r[15]}}, zero_off_r}) : -rdn_w;
    cnt_w   = {{(CNT_W-35){prodc_w[34]}}, prodc_w} - {{(CNT_W-18){r_w[17]}}, r_w};
  end

  // Phase update with the registered count.
  logic signed [SUM_W-1:0] cnt_ext_w;
  logic [NW-1:0]           sc_inc_w;
  logic                    sc_end_w;
  assign cnt_ext_w = {{(SUM_W-CNT_W){cnt_r[CNT_W-1]}}, cnt_r};
  assign sc_inc_w  = sc_r + NW'(1);
  assign sc_end_w  = (sc_inc_w >= n_w);

  // Difference of the phase sums.
  logic signed [DIF_W-1:0] diff_w;
  logic [DIF_W-1:0]        dmag_w;
  assign diff_w = {sig_sum_r[SUM_W-1], sig_sum_r} - {zero_sum_r[SUM_W-1], zero_sum_r};
  assign dmag_w = diff_w[DIF_W-1] ? DIF_W'(-diff_w) : DIF_W'(diff_w);

  // Shared multiplier factor.
  logic [31:0] fb_w;
  assign fb_w = gain_sel_r ? gain_r : scale_r;

  // Divider step. On the 1 V range the divisor is ten times the averaging
  // count, which folds the divide-by-ten prescale into the mean.
  logic [DVW:0]   dt_w;
  logic           dge_w;
  logic [DVW-1:0] div_n_w;
  assign dt_w    = {div_rem_r, div_q_r[DW-1]};
  assign dge_w   = (dt_w >= {1'b0, div_d_r});
  assign div_n_w = (rc_w == RNG_1V) ? ((DVW'(n_w) << 3) + (DVW'(n_w) << 1)) : DVW'(n_w);

  // Quotient magnitude; a 1 V mean that would saturate is held at its tenth.
  logic [63:0] quo_w;
  assign quo_w = ((rc_w == RNG_1V) && (64'(div_q_r) > MAG_1V_MAX)) ? MAG_1V_MAX
                                                                    : 64'(div_q_r);

  // Constant prescale products and the overload compare.
  logic signed [63:0] v64_w;
  logic signed [63:0] v10_w;
  logic signed [63:0] v100_w;
  logic [16:0]        lim_w;
  logic signed [63:0] lim_sh_w;
  logic               ovl_w;
  always_comb begin
    v64_w  = 64'(v_r);
    v10_w  = (v64_w <<< 3) + (v64_w <<< 1);
    v100_w = (v64_w <<< 6) + (v64_w <<< 5) + (v64_w <<< 2);
    case (rc_w)
      RNG_1K, RNG_1M:   lim_w = LIM_HIGH;
      RNG_100K:         lim_w = LIM_MID;
      RNG_10K, RNG_10M: lim_w = LIM_LOW;
      default:          lim_w = (rc_w >= RNG_DIODE) ? LIM_LOW : 17'd0;
    endcase
    lim_sh_w = $signed(64'(lim_w) << READING_FRAC_BITS);
    ovl_w    = (lim_w != 17'd0) && (v100_w >= lim_sh_w);
  end

  assign cfg_ready = 1'b1;

  // Configuration, autozero state and result handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adc_step_r  <= '0;
      zero_off_r  <= '0;
      scale_r     <= '0;
      avg_r       <= 4'd1;
      range_r     <= RNG_10V;
      cal_off_r   <= '0;
      gain_r      <= 32'h4000_0000;
      rel_r       <= '0;
      phase_r     <= PH_DROP_SIG;
      sc_r        <= '0;
      sig_sum_r   <= '0;
      zero_sum_r  <= '0;
      to_zero_r   <= 1'b0;
      to_sig_r    <= 1'b0;
      rd_due_r    <= 1'b0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (op == DP_PHASE) begin
        to_zero_r <= 1'b0;
        to_sig_r  <= 1'b0;
        rd_due_r  <= 1'b0;
        case (phase_r)
          PH_SIGNAL: begin
            sig_sum_r <= sig_sum_r + cnt_ext_w;
            sc_r      <= sc_inc_w;
            if (sc_end_w) begin
              phase_r   <= PH_DROP_ZERO;
              sc_r      <= '0;
              to_zero_r <= 1'b1;
            end
          end
          PH_DROP_ZERO: begin
            phase_r    <= PH_ZERO;
            sc_r       <= '0;
            zero_sum_r <= '0;
          end
          PH_ZERO: begin
            zero_sum_r <= zero_sum_r + cnt_ext_w;
            sc_r       <= sc_inc_w;
            if (sc_end_w) begin
              phase_r  <= PH_DROP_SIG;
              sc_r     <= '0;
              to_sig_r <= 1'b1;
              rd_due_r <= 1'b1;
            end
          end
          default: begin
            phase_r   <= PH_SIGNAL;
            sc_r      <= '0;
            sig_sum_r <= '0;
          end
        endcase
      end

      // Register writes; a new scale or averaging count restarts the cycle.
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ADC_STEP:    adc_step_r <= cfg_data[15:0];
          CFG_ZERO_OFFSET: zero_off_r <= $signed(cfg_data[15:0]);
          CFG_COUNT_SCALE: begin
            scale_r    <= cfg_data[31:0];
            phase_r    <= PH_DROP_SIG;
            sc_r       <= '0;
            sig_sum_r  <= '0;
            zero_sum_r <= '0;
          end
          CFG_AVG_COUNT: begin
            avg_r      <= cfg_data[3:0];
            phase_r    <= PH_DROP_SIG;
            sc_r       <= '0;
            sig_sum_r  <= '0;
            zero_sum_r <= '0;
          end
          CFG_RANGE_CODE:  range_r   <= cfg_data[3:0];
          CFG_CAL_OFFSET:  cal_off_r <= $signed(cfg_data);
          CFG_CAL_GAIN:    gain_r    <= cfg_data[31:0];
          CFG_REL_OFFSET:  rel_r     <= $signed(cfg_data);
          default: ;
        endcase
      end

      // Divider step counter.
      if (op == DP_DIV_BASE) begin
        div_cnt_r <= DCW'(DW);
      end else if (op == DP_DIV_STEP) begin
        div_cnt_r <= div_cnt_r - DCW'(1);
      end

      // Result register: a finished transaction may wait here.
      if (op == DP_FINISH) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Arithmetic registers and result payload.
  always_ff @(posedge clk) begin
    case (op)
      DP_LOAD: cnt_r <= cnt_w;
      DP_DIFF: begin
        neg_r      <= diff_w[DIF_W-1];
        mop_r      <= RD_W'(dmag_w);
        gain_sel_r <= 1'b0;
      end
      DP_MUL_LO: prod_r <= 64'(mop_r[31:0]) * 64'(fb_w);
      DP_MUL_HI: begin
        acc_r  <= ACC_W'(prod_r);
        prod_r <= 64'(mop_r[RD_W-1:32]) * 64'(fb_w);
      end
      DP_MUL_ACC: acc_r <= acc_r + {prod_r[RD_W-1:0], 32'd0};
      DP_DIV_BASE: begin
        div_q_r   <= DW'(acc_r >> SHR);
        div_d_r   <= div_n_w;
        div_rem_r <= '0;
      end
      DP_DIV_STEP: begin
        div_q_r   <= {div_q_r[DW-2:0], dge_w};
        div_rem_r <= dge_w ? DVW'(dt_w - {1'b0, div_d_r}) : DVW'(dt_w);
      end
      DP_QUO_SAT: v_r <= sgn_sat48(neg_r, quo_w);
      DP_PRE: begin
        case (rc_w)
          RNG_100V, RNG_100K: v_r <= sat48(v10_w);
          RNG_1K, RNG_1M:     v_r <= sat48(v100_w);
          default:            v_r <= v_r;
        endcase
      end
      DP_OFFSET: v_r <= sat48(v64_w + 64'(cal_off_r));
      DP_GAIN_LOAD: begin
        neg_r      <= v_r[RD_W-1];
        mop_r      <= mag48(v_r);
        gain_sel_r <= 1'b1;
      end
      DP_GAIN_SAT: v_r <= sgn_sat48(neg_r, 64'(acc_r >> 30));
      DP_REL: begin
        if (rc_w < RNG_DIODE) begin
          v_r <= sat48(v64_w - 64'(rel_r));
        end
      end
      DP_FINISH: begin
        out_tz_r  <= to_zero_r;
        out_ts_r  <= to_sig_r;
        out_rv_r  <= rd_due_r;
        out_rd_r  <= rd_due_r ? v_r : '0;
        out_ovl_r <= rd_due_r && ovl_w;
      end
      default: ;
    endcase
  end

  assign sts.reading_due = rd_due_r;
  assign sts.div_last    = (div_cnt_r == DCW'(1));
  assign sts.out_busy    = out_valid_r;

  assign out_valid            = out_valid_r;
  assign out_switch_to_zero   = out_tz_r;
  assign out_switch_to_signal = out_ts_r;
  assign out_reading_valid    = out_rv_r;
  assign out_reading          = out_rd_r;
  assign out_overload         = out_ovl_r;

  // The sample counter never passes the averaging count.
  a_sc_bound: assert property (@(posedge clk) disable iff (!rst_n) sc_r <= n_w)
    else $error("sample counter beyond averaging count");

  // Only phases of the autozero cycle are ever reached.
  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_ZERO)
    else $error("autozero phase out of range");

  // A reading is only due on the packet that returns to the signal input.
  a_due_sig: assert property (@(posedge clk) disable iff (!rst_n)
    rd_due_r |-> to_sig_r)
    else $error("reading due without switch to signal");

  // A finished transaction is always presented on the result channel.
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    op == DP_FINISH |=> out_valid_r)
    else $error("finished transaction not presented");

  // Reading fields are idle when no reading is given.
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rv_r) |-> (out_rd_r == '0 && !out_ovl_r))
    else $error("reading fields set without a reading");

endmodule

### design/multislope_adc_autozero_reading.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multislope_adc_autozero_reading
// Turns multislope ADC result packets into autozeroed, calibrated readings.
// ----------------------------------------------------------------------------
// Usage: each transaction on in_ch carries one ADC packet; each packet yields
// exactly one transaction on out_ch. The block drops one packet, sums the
// averaging count of signal packets and flags switch_to_zero, drops one more,
// sums as many zero packets and flags switch_to_signal together with a reading
// (Q23.24 by default) and the range overload flag. cfg_ch writes registers by
// index, always ready; writing count_scale or avg_count restarts the cycle.
// A packet that closes no cycle is loaded, updates the phase and then goes to
// the output register. The closing packet also runs the reading computation;
// the bit-serial divider for the mean works on DW = max(25 + READING_FRAC_BITS,
// 48) bits (49 by default), with a shared 32-bit multiplier for scale
// and gain. On the 1 V range the divide by ten is folded into the same divide.
// One packet is in work at a time; in_ch.ready is high while the block idles.
// A result waits in the output register while out_ch stalls, and the next
// packet is accepted and worked on meanwhile.
// Reset (rst_n low, synchronous) restores register defaults and phase zero.
// ----------------------------------------------------------------------------
module multislope_adc_autozero_reading
  import madc_pkg::*;
#(
  parameter int MAX_AVERAGE       = MAX_AVERAGE_DEF,
  parameter int READING_FRAC_BITS = READING_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  madc_in_if.sink      in_ch,
  madc_out_if.source   out_ch,
  madc_cfg_if.sink     cfg_ch
);

  dp_op_t    op;
  madc_sts_t sts;

  // Sequencer.
  madc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .op        (op)
  );

  // Datapath.
  madc_dp #(
    .MAX_AVERAGE       (MAX_AVERAGE),
    .READING_FRAC_BITS (READING_FRAC_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .op                   (op),
    .sts                  (sts),
    .up_count             (in_ch.up_count),
    .total_count          (in_ch.total_count),
    .rundown_sign         (in_ch.rundown_sign),
    .rundown_count        (in_ch.rundown_count),
    .cfg_valid            (cfg_ch.valid),
    .cfg_ready            (cfg_ch.ready),
    .cfg_index            (cfg_ch.index),
    .cfg_data             (cfg_ch.data),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_switch_to_zero   (out_ch.switch_to_zero),
    .out_switch_to_signal (out_ch.switch_to_signal),
    .out_reading_valid    (out_ch.reading_valid),
    .out_reading          (out_ch.reading),
    .out_overload         (out_ch.overload)
  );

endmodule

### bench/multislope_adc_autozero_reading_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multislope_adc_autozero_reading_test
// Self-checking bench for the autozero reading block. A short table of
// directed packets comes first. After it come phases of random packets, each
// with a new register setting and one of four idle patterns in turn. An
// in-bench model predicts the results after the first four directed rows, and
// a scoreboard compares each result field by field.
// ----------------------------------------------------------------------------
module multislope_adc_autozero_reading_test;

  localparam int  FRAC      = 24;
  localparam int  NUM_PHASE = 12;
  localparam int  PHASE_LEN = 160;
  localparam int  LIMIT     = 1000000;
  localparam int  NUM_DIR   = 20;

  typedef struct {
    bit [15:0] up;
    bit [11:0] total;
    bit        sgn;
    bit [15:0] rdn;
  } packet_t;

  typedef struct {
    bit        to_zero;
    bit        to_signal;
    bit        valid;
    bit [47:0] reading;
    bit        overload;
  } reading_t;

  typedef struct {
    packet_t  pkt;
    bit       typed;
    reading_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  madc_in_if  in_if ();
  madc_out_if out_if ();
  madc_cfg_if cfg_if ();

  multislope_adc_autozero_reading u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #1 clk = ~clk;

  // Model copy of the registers.
  bit [15:0] m_step;
  longint    m_zoff;
  bit [63:0] m_scale;
  bit [3:0]  m_avg;
  bit [3:0]  m_range;
  longint    m_coff;
  bit [63:0] m_gain;
  longint    m_rel;

  // Model copy of the autozero state.
  bit [2:0] m_phase;
  int       m_samples;
  longint   m_sig_sum;
  longint   m_zero_sum;

  reading_t expected_q[$];
  int       errors = 0;
  int       cycles = 0;
  int       snd_idle = 0;
  int       rcv_stall = 0;

  localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint MIN48 = -MAX48 - 1;

  function automatic longint clamp48(longint v);
    return v > MAX48 ? MAX48 : (v < MIN48 ? MIN48 : v);
  endfunction

  function automatic bit [63:0] magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint signed_mag(bit neg, bit [63:0] m);
    bit [63:0] mm;
    mm = (m > 64'h8000_0000_0000) ? 64'h8000_0000_0000 : m;
    return neg ? clamp48(-longint'(mm)) : clamp48(longint'(mm));
  endfunction

  function automatic int avg_effective();
    if (m_avg == 0) return 1;
    if (m_avg > 10) return 10;
    return int'(m_avg);
  endfunction

  function automatic void restart_cycle();
    m_phase = madc_pkg::PH_DROP_SIG;
    m_samples = 0;
    m_sig_sum = 0;
    m_zero_sum = 0;
  endfunction

  function automatic void reset_model();
    m_step = 0; m_zoff = 0; m_scale = 0; m_avg = 1;
    m_range = madc_pkg::RNG_10V; m_coff = 0; m_gain = 64'd1073741824; m_rel = 0;
    restart_cycle();
  endfunction

  function automatic void model_write(bit [3:0] idx, bit [47:0] d);
    case (idx)
      madc_pkg::CFG_ADC_STEP:    m_step = d[15:0];
      madc_pkg::CFG_ZERO_OFFSET: m_zoff = longint'($signed(d[15:0]));
      madc_pkg::CFG_COUNT_SCALE: begin
        m_scale = 64'(d[31:0]);
        restart_cycle();
      end
      madc_pkg::CFG_AVG_COUNT: begin
        m_avg = d[3:0];
        restart_cycle();
      end
      madc_pkg::CFG_RANGE_CODE:  m_range = d[3:0];
      madc_pkg::CFG_CAL_OFFSET:  m_coff = longint'($signed(d[47:0]));
      madc_pkg::CFG_CAL_GAIN:    m_gain = 64'(d[31:0]);
      madc_pkg::CFG_REL_OFFSET:  m_rel = longint'($signed(d[47:0]));
      default: ;
    endcase
  endfunction

  // Mean difference scaled to volts, then prescale, calibration and relative.
  function automatic void calibrated_reading(output bit [47:0] rd, output bit ovl);
    bit [63:0] m, lo, hi, q;
    bit [3:0]  rc;
    longint    diff, v, limit;
    diff = m_sig_sum - m_zero_sum;
    m = magnitude(diff);
    lo = (m & 64'hFFFF_FFFF) * m_scale;
    hi = (m >> 32) * m_scale;
    q = (hi << (32 - (48 - FRAC))) + (lo >> (48 - FRAC));
    v = signed_mag(diff < 0, q / 64'(avg_effective()));
    rc = (m_range > madc_pkg::RNG_LAST) ? madc_pkg::RNG_10V : m_range;
    case (rc)
      madc_pkg::RNG_1V:                     v = v / 10;
      madc_pkg::RNG_100V, madc_pkg::RNG_100K: v = clamp48(v * 10);
      madc_pkg::RNG_1K, madc_pkg::RNG_1M:     v = clamp48(v * 100);
      default: ;
    endcase
    v = clamp48(v + m_coff);
    m = magnitude(v);
    lo = (m & 64'hFFFF_FFFF) * m_gain;
    hi = (m >> 32) * m_gain;
    v = signed_mag(v < 0, (hi << 2) + (lo >> 30));
    if (rc < madc_pkg::RNG_DIODE) v = clamp48(v - m_rel);
    case (rc)
      madc_pkg::RNG_1K, madc_pkg::RNG_1M:     limit = longint'(madc_pkg::LIM_HIGH);
      madc_pkg::RNG_100K:                   limit = longint'(madc_pkg::LIM_MID);
      madc_pkg::RNG_10K, madc_pkg::RNG_10M:   limit = longint'(madc_pkg::LIM_LOW);
      default: limit = (rc >= madc_pkg::RNG_DIODE) ? longint'(madc_pkg::LIM_LOW) : 0;
    endcase
    rd = v[47:0];
    ovl = (limit != 0) && (v * 100 >= (limit << FRAC));
  endfunction

  // Advance the autozero cycle by one packet and return its result.
  function automatic reading_t autozero_step(packet_t p);
    reading_t r;
    longint   rr, cnt;
    int       n;
    r = '{default: 0};
    rr = p.sgn ? longint'(p.rdn) + m_zoff : -longint'(p.rdn);
    cnt = (((longint'(p.total) + 1) >>> 1) - longint'(p.up)) * longint'(m_step) - rr;
    n = avg_effective();
    case (m_phase)
      madc_pkg::PH_SIGNAL: begin
        m_sig_sum += cnt;
        m_samples++;
        if (m_samples >= n) begin
          m_phase = madc_pkg::PH_DROP_ZERO;
          m_samples = 0;
          r.to_zero = 1;
        end
      end
      madc_pkg::PH_DROP_ZERO: begin
        m_phase = madc_pkg::PH_ZERO;
        m_samples = 0;
        m_zero_sum = 0;
      end
      madc_pkg::PH_ZERO: begin
        m_zero_sum += cnt;
        m_samples++;
        if (m_samples >= n) begin
          m_phase = madc_pkg::PH_DROP_SIG;
          m_samples = 0;
          r.to_signal = 1;
          r.valid = 1;
          calibrated_reading(r.reading, r.overload);
        end
      end
      default: begin
        m_phase = madc_pkg::PH_SIGNAL;
        m_samples = 0;
        m_sig_sum = 0;
      end
    endcase
    return r;
  endfunction

  // Send one packet; called at a falling edge, returns at a falling edge.
  task automatic send_packet(packet_t p, bit typed, reading_t typed_res);
    reading_t r;
    while ($urandom_range(99) < snd_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.up_count      <= p.up;
    in_if.total_count   <= p.total;
    in_if.rundown_sign  <= p.sgn;
    in_if.rundown_count <= p.rdn;
    do @(posedge clk); while (!in_if.ready);
    r = autozero_step(p);
    expected_q.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  // Write all registers in one burst; called with the block idle.
  task automatic write_registers(bit [47:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= 4'(i);
      cfg_if.data  <= vals[i];
      do @(posedge clk); while (!cfg_if.ready);
      model_write(4'(i), vals[i]);
      @(negedge clk);
    end
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  // Pick a register value: an extreme, zero or random within its width.
  function automatic bit [47:0] pick(int w, bit is_signed);
    bit [47:0] v;
    int        k;
    k = $urandom_range(7);
    v = 48'({$urandom, $urandom});
    case (k)
      0: v = is_signed ? (48'h1 << (w - 1)) : 48'h0;
      1: v = is_signed ? ((48'h1 << (w - 1)) - 1) : ((48'h1 << w) - 1);
      2: v = 48'h0;
      default: v = v & ((48'h1 << w) - 1);
    endcase
    if (is_signed && v[w-1]) v = v | ~((48'h1 << w) - 1);
    return v;
  endfunction

  function automatic packet_t random_packet();
    packet_t p;
    p.up = 16'($urandom);
    p.total = 12'($urandom);
    p.sgn = 1'($urandom);
    p.rdn = 16'($urandom);
    return p;
  endfunction

  // Each accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    reading_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("result transaction with no expectation waiting");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_if.switch_to_zero !== e.to_zero) begin
          $error("switch_to_zero expected %0d actual %0d", e.to_zero, out_if.switch_to_zero);
          errors++;
        end
        if (out_if.switch_to_signal !== e.to_signal) begin
          $error("switch_to_signal expected %0d actual %0d", e.to_signal,
                 out_if.switch_to_signal);
          errors++;
        end
        if (out_if.reading_valid !== e.valid) begin
          $error("reading_valid expected %0d actual %0d", e.valid, out_if.reading_valid);
          errors++;
        end
        if (out_if.reading !== e.reading) begin
          $error("reading expected %0h actual %0h", e.reading, out_if.reading);
          errors++;
        end
        if (out_if.overload !== e.overload) begin
          $error("overload expected %0d actual %0d", e.overload, out_if.overload);
          errors++;
        end
      end
    end
  end

  // Receiver stalls at random.
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= rcv_stall);
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    dir_row_t  dir_tab[NUM_DIR];
    reading_t  zero_res;
    bit [47:0] regs[8];
    packet_t   p;

    in_if.valid = 1'b0;
    in_if.up_count = '0;
    in_if.total_count = '0;
    in_if.rundown_sign = 1'b0;
    in_if.rundown_count = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    reset_model();

    // Directed table: the first four rows run at reset values, where a zero
    // scale gives a zero reading and the averaging count of one makes every
    // second packet close a phase.
    zero_res = '{default: 0};
    foreach (dir_tab[i]) dir_tab[i] = '{pkt: '{default: 0}, typed: 0, res: zero_res};
    dir_tab[0] = '{'{16'hFFFF, 12'hFFF, 1'b1, 16'hFFFF}, 1, zero_res};
    dir_tab[1] = '{'{16'h0000, 12'h000, 1'b0, 16'h0000}, 1,
                   '{1'b1, 1'b0, 1'b0, 48'h0, 1'b0}};
    dir_tab[2] = '{'{16'h1234, 12'h800, 1'b1, 16'h8000}, 1, zero_res};
    dir_tab[3] = '{'{16'hFFFF, 12'hFFF, 1'b0, 16'hFFFF}, 1,
                   '{1'b0, 1'b1, 1'b1, 48'h0, 1'b0}};
    // Field extremes under full-scale registers, checked by the model.
    dir_tab[4]  = '{'{16'h0000, 12'hFFF, 1'b0, 16'h0000}, 0, zero_res};
    dir_tab[5]  = '{'{16'h0000, 12'hFFF, 1'b0, 16'h0000}, 0, zero_res};
    dir_tab[6]  = '{'{16'h0000, 12'h000, 1'b1, 16'hFFFF}, 0, zero_res};
    dir_tab[7]  = '{'{16'hFFFF, 12'h000, 1'b1, 16'h0000}, 0, zero_res};
    dir_tab[8]  = '{'{16'hFFFF, 12'h000, 1'b1, 16'h0000}, 0, zero_res};
    dir_tab[9]  = '{'{16'h0000, 12'hFFF, 1'b0, 16'hFFFF}, 0, zero_res};
    dir_tab[10] = '{'{16'h5555, 12'hAAA, 1'b1, 16'hAAAA}, 0, zero_res};
    dir_tab[11] = '{'{16'hAAAA, 12'h555, 1'b0, 16'h5555}, 0, zero_res};
    dir_tab[12] = '{'{16'h0001, 12'h001, 1'b1, 16'h0001}, 0, zero_res};
    dir_tab[13] = '{'{16'h8000, 12'h800, 1'b0, 16'h8000}, 0, zero_res};
    dir_tab[14] = '{'{16'h7FFF, 12'h7FF, 1'b1, 16'h7FFF}, 0, zero_res};
    dir_tab[15] = '{'{16'h0000, 12'h000, 1'b0, 16'h0000}, 0, zero_res};
    dir_tab[16] = '{'{16'hFFFF, 12'hFFF, 1'b1, 16'hFFFF}, 0, zero_res};
    dir_tab[17] = '{'{16'h0000, 12'hFFE, 1'b0, 16'hFFFF}, 0, zero_res};
    dir_tab[18] = '{'{16'hFFFF, 12'h001, 1'b1, 16'h0000}, 0, zero_res};
    dir_tab[19] = '{'{16'h0F0F, 12'hF0F, 1'b0, 16'hF0F0}, 0, zero_res};

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_DIR; i++) begin
      if (i == 4) begin
        wait_idle();
        // Full-scale step and scale, averaging count of zero acting as one,
        // 1 V range with its divide-by-ten prescale.
        regs = '{48'hFFFF, 48'hFFFF_FFFF_8000, 48'hFFFF_FFFF, 48'h0,
                 48'(madc_pkg::RNG_1V), 48'h0, 48'h4000_0000, 48'h0};
        write_registers(regs);
      end
      send_packet(dir_tab[i].pkt, dir_tab[i].typed, dir_tab[i].res);
    end

    // Random phases: new registers and one of four idle patterns in turn.
    for (int ph = 0; ph < NUM_PHASE; ph++) begin
      wait_idle();
      snd_idle = 0;
      rcv_stall = 0;
      case (ph % 4)
        1: snd_idle = 76;
        2: rcv_stall = 76;
        3: begin
          snd_idle = 29;
          rcv_stall = 29;
        end
        default: ;
      endcase
      regs[0] = pick(16, 0);
      regs[1] = pick(16, 1);
      regs[2] = pick(32, 0);
      regs[3] = 48'($urandom_range(15));
      regs[4] = 48'((ph < 12) ? ph : $urandom_range(15));
      if (ph == NUM_PHASE - 1) regs[4] = 48'hF;
      regs[5] = pick(48, 1);
      regs[6] = pick(32, 0);
      regs[7] = pick(48, 1);
      // Keep half the phases near unity gain and small offsets so that
      // readings land around the overload limits rather than saturating.
      if (ph % 2 == 0) begin
        regs[2] = 48'($urandom_range(32'h00FF_FFFF));
        regs[5] = 48'($urandom_range(32'h0FFF_FFFF));
        regs[6] = 48'($urandom_range(32'h4800_0000, 32'h3800_0000));
        regs[7] = ($urandom_range(1) == 1) ? 48'h0 : 48'($urandom_range(32'h0FFF_FFFF));
      end
      write_registers(regs);
      for (int k = 0; k < PHASE_LEN; k++) begin
        p = random_packet();
        send_packet(p, 0, zero_res);
      end
    end

    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### multislope_adc_autozero_reading.f
design/madc_pkg.sv
design/madc_in_if.sv
design/madc_out_if.sv
design/madc_cfg_if.sv
design/madc_ctrl.sv
design/madc_dp.sv
design/multislope_adc_autozero_reading.sv
bench/multislope_adc_autozero_reading_test.sv
